// File: rtl/sedm_pkg.sv
// ----------------------------------------------------------------------------
// sedm_pkg
// Sizes, beat types and the Cayley-Dickson sign rule of the sedenion multiplier
// ----------------------------------------------------------------------------
package sedm_pkg;

	localparam int DIMENSION       = 16;
	localparam int COMPONENT_WIDTH = 16;
	localparam int DIM_LOG         = $clog2(DIMENSION);
	localparam int ADDR_W          = (DIM_LOG > 0) ? DIM_LOG : 1;
	localparam int POS_W           = 4;
	localparam int PROD_W          = 36;

	typedef struct packed {
		logic [POS_W-1:0]                  position;
		logic signed [COMPONENT_WIDTH-1:0] left_component;
		logic signed [COMPONENT_WIDTH-1:0] right_component;
		logic                              final_load;
	} operand_beat_t;

	typedef struct packed {
		logic [POS_W-1:0]         out_position;
		logic signed [PROD_W-1:0] product_component;
		logic                     out_last;
	} result_beat_t;

	// sign of e_i * e_j, walked from the top halving level down
	function automatic logic cd_neg(input logic [ADDR_W-1:0] i, input logic [ADDR_W-1:0] j);
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [ADDR_W-1:0] t;
		logic [ADDR_W-1:0] msk;
		logic              n;
		a = i;
		b = j;
		n = 1'b0;
		for (int lvl = DIM_LOG - 1; lvl >= 0; lvl--) begin
			msk = ADDR_W'((1 << lvl) - 1);
			unique case ({a[lvl], b[lvl]})
				2'b00: begin
					a = a & msk;
					b = b & msk;
				end
				2'b01: begin
					t = a & msk;
					a = b & msk;
					b = t;
				end
				2'b10: begin
					n = n ^ ((b & msk) != '0);
					a = a & msk;
					b = b & msk;
				end
				default: begin
					n = n ^ ((b & msk) == '0);
					t = a & msk;
					a = b & msk;
					b = t;
				end
			endcase
		end
		return n;
	endfunction

endpackage

// File: rtl/sedm_operand_if.sv
// ----------------------------------------------------------------------------
// sedm_operand_if
// Operand load channel: one component of each operand per beat
// ----------------------------------------------------------------------------
interface sedm_operand_if import sedm_pkg::*; ();
	logic          valid;
	logic          ready;
	operand_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sedm_result_if.sv
// ----------------------------------------------------------------------------
// sedm_result_if
// Product channel: one product component per beat
// ----------------------------------------------------------------------------
interface sedm_result_if import sedm_pkg::*; ();
	logic         valid;
	logic         ready;
	result_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sedm_ram.sv
// ----------------------------------------------------------------------------
// sedm_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module sedm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: rtl/sedenion_multiply.sv
// ----------------------------------------------------------------------------
// sedenion_multiply
// Integer sedenion product by the Cayley-Dickson rule, one shared MAC
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  operand   in   position, left_component, right_component, final_load
//  result    out  out_position, product_component, out_last
//
//  a load beat writes both operand stores
//  a beat with final_load starts 256 multiply-accumulates on one MAC, one a cycle unless
//  the result stalls, each through the read, multiply and accumulate stages in turn
//  loads are refused until the last product beat is in the output register
//  a stalled result freezes the whole MAC pipeline, reads included
//  arst_n clears control state only; the stores hold garbage until written
// ----------------------------------------------------------------------------
module sedenion_multiply import sedm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	sedm_operand_if.sink   operand,
	sedm_result_if.source  result
);
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ISSUE = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	localparam logic [ADDR_W-1:0] IDX_MAX = ADDR_W'(DIMENSION - 1);

	state_t                            state_q;
	logic [ADDR_W-1:0]                 i_q;
	logic [ADDR_W-1:0]                 k_q;
	logic                              in_fire;
	logic                              wr_en;
	logic                              stall;
	logic                              load_out;

	logic                              valid_s1;
	logic                              neg_s1;
	logic                              first_s1;
	logic                              lastterm_s1;
	logic [ADDR_W-1:0]                 k_s1;
	logic signed [COMPONENT_WIDTH-1:0] l_rd;
	logic signed [COMPONENT_WIDTH-1:0] r_rd;
	logic signed [2*COMPONENT_WIDTH-1:0] mul;

	logic                              valid_s2;
	logic                              neg_s2;
	logic                              first_s2;
	logic                              lastterm_s2;
	logic [ADDR_W-1:0]                 k_s2;
	logic signed [PROD_W-1:0]          prod_s2;

	logic signed [PROD_W-1:0]          acc_q;
	logic signed [PROD_W-1:0]          term;
	logic signed [PROD_W-1:0]          sum;
	result_beat_t                      out_q;
	logic                              out_valid_q;

	assign in_fire  = operand.valid && operand.ready;
	assign wr_en    = in_fire && (int'(operand.data.position) < DIMENSION);
	assign stall    = out_valid_q && !result.ready;
	assign load_out = valid_s2 && lastterm_s2 && !stall;

	assign operand.ready = (state_q == S_IDLE);
	assign result.valid  = out_valid_q;
	assign result.data   = out_q;

	// operand stores
	sedm_ram #(.WIDTH(COMPONENT_WIDTH), .DEPTH(DIMENSION)) u_left_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (operand.data.position[ADDR_W-1:0]),
		.wr_data (operand.data.left_component),
		.rd_en   (!stall),
		.rd_addr (i_q),
		.rd_data (l_rd)
	);

	sedm_ram #(.WIDTH(COMPONENT_WIDTH), .DEPTH(DIMENSION)) u_right_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (operand.data.position[ADDR_W-1:0]),
		.wr_data (operand.data.right_component),
		.rd_en   (!stall),
		.rd_addr (i_q ^ k_q),
		.rd_data (r_rd)
	);

	// issue sequencer: k picks the product component, i walks the terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && operand.data.final_load) begin
						state_q <= S_ISSUE;
						i_q     <= '0;
						k_q     <= '0;
					end
				end
				S_ISSUE: begin
					if (!stall) begin
						i_q <= i_q + 1'b1;
						if (i_q == IDX_MAX) begin
							k_q <= k_q + 1'b1;
							if (k_q == IDX_MAX) begin
								state_q <= S_DRAIN;
							end
						end
					end
				end
				default: begin
					if (load_out && k_s2 == IDX_MAX) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= (state_q == S_ISSUE);
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			neg_s1      <= cd_neg(i_q, i_q ^ k_q);
			first_s1    <= (i_q == '0);
			lastterm_s1 <= (i_q == IDX_MAX);
			k_s1        <= k_q;
		end
	end

	// multiply stage
	assign mul = l_rd * r_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			prod_s2     <= PROD_W'(mul);
			neg_s2      <= neg_s1;
			first_s2    <= first_s1;
			lastterm_s2 <= lastterm_s1;
			k_s2        <= k_s1;
		end
	end

	// accumulate stage
	assign term = neg_s2 ? -prod_s2 : prod_s2;
	assign sum  = (first_s2 ? '0 : acc_q) + term;

	always_ff @(posedge clk) begin
		if (valid_s2 && !stall) begin
			acc_q <= sum;
		end
		if (load_out) begin
			out_q.out_position      <= POS_W'(k_s2);
			out_q.product_component <= sum;
			out_q.out_last          <= (k_s2 == IDX_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// checks
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!valid_s1 && !valid_s2))
		else $error("pipeline busy while loads are taken");

	a_final_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && operand.data.final_load) |=> (state_q == S_ISSUE && i_q == '0))
		else $error("final load beat did not start the product");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && stall) |=> ($stable(prod_s2) && $stable(acc_q) && valid_s2))
		else $error("mac pipeline moved under a stalled result");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && k_s2 == IDX_MAX) |=> (out_valid_q && out_q.out_last && state_q == S_IDLE))
		else $error("last product beat out of step with the sequencer");
endmodule
